>>> rtl/interrupt_priority_selector_defines.svh
// ---------------------------------------------------------------------------
// Interrupt priority selector: assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef INTERRUPT_PRIORITY_SELECTOR_DEFINES_SVH
`define INTERRUPT_PRIORITY_SELECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define IPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ips_pkg.sv
// ---------------------------------------------------------------------------
// Interrupt priority selector: package
// Opcodes, source descriptors and shared types.
// ---------------------------------------------------------------------------
package ips_pkg;

	localparam int SRC_W  = 5;
	localparam int LEAVES = 32;
	localparam int PRIO_W = 5;
	localparam int SUB_W  = 3;
	localparam int CODE_W = 12;
	localparam int REG_W  = 16;

	localparam logic [PRIO_W-1:0] NMI_PRIO       = 5'd16;
	localparam logic [3:0]        EXT_RESET_PRIO = 4'd1;
	localparam logic [CODE_W-1:0] EXT_CODE_BASE  = 12'h200;
	localparam int                EXT_SRC        = 1;

	typedef enum logic [1:0] {
		OP_PEND   = 2'd0,
		OP_LEVEL  = 2'd1,
		OP_ACCEPT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_A = 2'd0,
		REG_B = 2'd1,
		REG_C = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              found;
		logic [SRC_W-1:0]  idx;
		logic [PRIO_W-1:0] prio;
	} best_t;

	function automatic logic [PRIO_W-1:0] src_prio(
		input logic [SRC_W-1:0] idx,
		input logic [REG_W-1:0] ra,
		input logic [REG_W-1:0] rb,
		input logic [REG_W-1:0] rc,
		input logic [3:0]       ext
	);
		logic [3:0] f;
		f = 4'd0;
		unique case (idx)
			5'd0:                      f = 4'd0;
			5'd1:                      f = ext;
			5'd2:                      f = rc[3:0];
			5'd3:                      f = rc[15:12];
			5'd4, 5'd5, 5'd6, 5'd7,
			5'd8:                      f = rc[11:8];
			5'd9:                      f = ra[15:12];
			5'd10:                     f = ra[11:8];
			5'd11, 5'd12:              f = ra[7:4];
			5'd13, 5'd14, 5'd15:       f = ra[3:0];
			5'd16, 5'd17, 5'd18, 5'd19: f = rb[7:4];
			5'd20, 5'd21, 5'd22, 5'd23: f = rc[7:4];
			5'd24:                     f = rb[15:12];
			5'd25, 5'd26:              f = rb[11:8];
			default:                   f = 4'd0;
		endcase
		return (idx == 5'd0) ? NMI_PRIO : {1'b0, f};
	endfunction

	function automatic logic [SUB_W-1:0] src_sub(input logic [SRC_W-1:0] idx);
		logic [SUB_W-1:0] s;
		unique case (idx)
			5'd4, 5'd11:               s = 3'd4;
			5'd5, 5'd16, 5'd20:        s = 3'd3;
			5'd6, 5'd13, 5'd17, 5'd21: s = 3'd2;
			5'd7, 5'd14, 5'd18, 5'd22,
			5'd25:                     s = 3'd1;
			default:                   s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [CODE_W-1:0] src_code(
		input logic [SRC_W-1:0]  idx,
		input logic [CODE_W-1:0] ext_code
	);
		logic [CODE_W-1:0] c;
		unique case (idx)
			5'd0:    c = 12'h1C0;
			5'd1:    c = ext_code;
			5'd2:    c = 12'h600;
			5'd3:    c = 12'h620;
			5'd4:    c = 12'h640;
			5'd5:    c = 12'h660;
			5'd6:    c = 12'h680;
			5'd7:    c = 12'h6A0;
			5'd8:    c = 12'h6C0;
			5'd9:    c = 12'h400;
			5'd10:   c = 12'h420;
			5'd11:   c = 12'h440;
			5'd12:   c = 12'h460;
			5'd13:   c = 12'h480;
			5'd14:   c = 12'h4A0;
			5'd15:   c = 12'h4C0;
			5'd16:   c = 12'h4E0;
			5'd17:   c = 12'h500;
			5'd18:   c = 12'h520;
			5'd19:   c = 12'h540;
			5'd20:   c = 12'h700;
			5'd21:   c = 12'h720;
			5'd22:   c = 12'h740;
			5'd23:   c = 12'h760;
			5'd24:   c = 12'h560;
			5'd25:   c = 12'h580;
			5'd26:   c = 12'h5A0;
			default: c = 12'h000;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/ips_arbiter.sv
// ---------------------------------------------------------------------------
// Interrupt priority selector: arbiter
// Compare tree picking the best raised source: priority, sub-priority,
// then lowest index.
// ---------------------------------------------------------------------------
module ips_arbiter #(
	parameter int N = 27
) (
	input  logic [N-1:0]                flags,
	input  logic [ips_pkg::REG_W-1:0]   prio_a,
	input  logic [ips_pkg::REG_W-1:0]   prio_b,
	input  logic [ips_pkg::REG_W-1:0]   prio_c,
	input  logic [3:0]                  ext_prio,
	output ips_pkg::best_t              best
);

	// key: raised, priority, sub-priority, inverted index (lower index wins)
	localparam int KEY_W   = 1 + ips_pkg::PRIO_W + ips_pkg::SUB_W + ips_pkg::SRC_W;
	localparam int NODES   = 2 * ips_pkg::LEAVES - 1;
	localparam int INNER   = ips_pkg::LEAVES - 1;

	logic [ips_pkg::LEAVES-1:0] flags_pad;
	logic [KEY_W-1:0]           node [NODES];

	assign flags_pad = ips_pkg::LEAVES'(flags);

	always_comb begin
		for (int i = 0; i < ips_pkg::LEAVES; i++) begin
			node[INNER + i] = {
				flags_pad[i],
				ips_pkg::src_prio(ips_pkg::SRC_W'(i), prio_a, prio_b, prio_c, ext_prio),
				ips_pkg::src_sub(ips_pkg::SRC_W'(i)),
				~ips_pkg::SRC_W'(i)
			};
		end
		// heap order: children of k are 2k+1 and 2k+2, built bottom up
		for (int k = INNER - 1; k >= 0; k--) begin
			node[k] = (node[2*k+1] >= node[2*k+2]) ? node[2*k+1] : node[2*k+2];
		end
	end

	always_comb begin
		best.found = node[0][KEY_W-1];
		best.prio  = node[0][KEY_W-2 -: ips_pkg::PRIO_W];
		best.idx   = ~node[0][ips_pkg::SRC_W-1:0];
	end

endmodule

>>> rtl/interrupt_priority_selector.sv
// ---------------------------------------------------------------------------
// Interrupt priority selector
// Items pass through the stage 1 register and the output register.
// Throughput: one item per cycle unless stalled; the state update and accept
// search run in the accepting cycle, the highest-priority search in stage 1.
// Reset: flags and priority registers clear, external level priority 1 with
// event code 0x200; no clearing pass, ready straight out of reset.
// ---------------------------------------------------------------------------
module interrupt_priority_selector #(
	parameter int NUM_SOURCES = 27
) (
	input  logic        clk,
	input  logic        arst_n,

	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] opcode, [6:2] source_index, [7] assert_flag, [11:8] irl_level
	input  logic [15:0] s_axis_tdata,

	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] highest_priority, [5] taken_valid, [17:6] event_code,
	// [22:18] taken_source
	output logic [23:0] m_axis_tdata,

	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ---- register file ----------------------------------------------------
	logic [ips_pkg::REG_W-1:0] prio_a_q, prio_b_q, prio_c_q;
	logic                      cfg_wr;
	ips_pkg::reg_idx_t         cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = ips_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_a_q <= '0;
			prio_b_q <= '0;
			prio_c_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				ips_pkg::REG_A: prio_a_q <= pwdata[ips_pkg::REG_W-1:0];
				ips_pkg::REG_B: prio_b_q <= pwdata[ips_pkg::REG_W-1:0];
				ips_pkg::REG_C: prio_c_q <= pwdata[ips_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			ips_pkg::REG_A: prdata = 32'(prio_a_q);
			ips_pkg::REG_B: prdata = 32'(prio_b_q);
			ips_pkg::REG_C: prdata = 32'(prio_c_q);
			default:        prdata = '0;
		endcase
	end

	// ---- input item fields ------------------------------------------------
	ips_pkg::op_t             in_op;
	logic [ips_pkg::SRC_W-1:0] in_idx;
	logic                     in_flag;
	logic [3:0]               in_level;

	assign in_op    = ips_pkg::op_t'(s_axis_tdata[1:0]);
	assign in_idx   = s_axis_tdata[6:2];
	assign in_flag  = s_axis_tdata[7];
	assign in_level = s_axis_tdata[11:8];

	// ---- flow control -----------------------------------------------------
	// Stage 1 holds the item's accept result and a snapshot of the state it
	// left; the output register moves on whenever it is empty or being taken.
	logic s1_valid_q;
	logic out_valid_q;
	logic adv_out;
	logic in_acc;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || adv_out;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)
				s1_valid_q <= 1'b1;
			else if (adv_out)
				s1_valid_q <= 1'b0;
			if (adv_out)
				out_valid_q <= s1_valid_q;
		end
	end

	// ---- architectural state ----------------------------------------------
	logic [NUM_SOURCES-1:0]     raised_q, raised_d;
	logic [3:0]                 ext_prio_q, ext_prio_d;
	logic [ips_pkg::CODE_W-1:0] ext_code_q, ext_code_d;

	// accept search over the current flags
	ips_pkg::best_t acc_best;

	ips_arbiter #(
		.N (NUM_SOURCES)
	) u_acc_arb (
		.flags    (raised_q),
		.prio_a   (prio_a_q),
		.prio_b   (prio_b_q),
		.prio_c   (prio_c_q),
		.ext_prio (ext_prio_q),
		.best     (acc_best)
	);

	logic                       tk_valid_d;
	logic [ips_pkg::CODE_W-1:0] tk_code_d;
	logic [ips_pkg::SRC_W-1:0]  tk_src_d;

	always_comb begin
		raised_d   = raised_q;
		ext_prio_d = ext_prio_q;
		ext_code_d = ext_code_q;
		tk_valid_d = 1'b0;
		tk_code_d  = '0;
		tk_src_d   = '0;
		unique case (in_op)
			ips_pkg::OP_PEND: begin
				// out-of-range indices match no bit and are dropped
				for (int i = 0; i < NUM_SOURCES; i++) begin
					if (in_idx == ips_pkg::SRC_W'(i))
						raised_d[i] = in_flag;
				end
			end
			ips_pkg::OP_LEVEL: begin
				ext_prio_d                  = ~in_level;
				ext_code_d                  = ips_pkg::EXT_CODE_BASE
				                              + {3'b000, in_level, 5'b00000};
				raised_d[ips_pkg::EXT_SRC]  = |(~in_level);
			end
			ips_pkg::OP_ACCEPT: begin
				if (acc_best.found) begin
					tk_valid_d = 1'b1;
					tk_code_d  = ips_pkg::src_code(acc_best.idx, ext_code_q);
					tk_src_d   = acc_best.idx;
					// level source stays raised while its lines hold
					for (int i = 0; i < NUM_SOURCES; i++) begin
						if (acc_best.idx == ips_pkg::SRC_W'(i) && i != ips_pkg::EXT_SRC)
							raised_d[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raised_q   <= '0;
			ext_prio_q <= ips_pkg::EXT_RESET_PRIO;
			ext_code_q <= ips_pkg::EXT_CODE_BASE;
		end else if (in_acc) begin
			raised_q   <= raised_d;
			ext_prio_q <= ext_prio_d;
			ext_code_q <= ext_code_d;
		end
	end

	// ---- stage 1: accept result plus post-item state snapshot -------------
	logic [NUM_SOURCES-1:0]     flags_s1;
	logic [3:0]                 ext_prio_s1;
	logic                       tk_valid_s1;
	logic [ips_pkg::CODE_W-1:0] tk_code_s1;
	logic [ips_pkg::SRC_W-1:0]  tk_src_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_s1    <= raised_d;
			ext_prio_s1 <= ext_prio_d;
			tk_valid_s1 <= tk_valid_d;
			tk_code_s1  <= tk_code_d;
			tk_src_s1   <= tk_src_d;
		end
	end

	// highest raised priority after the item; the user must keep the registers
	// stable while items are in flight, the block itself does not enforce it
	ips_pkg::best_t hp_best;

	ips_arbiter #(
		.N (NUM_SOURCES)
	) u_hp_arb (
		.flags    (flags_s1),
		.prio_a   (prio_a_q),
		.prio_b   (prio_b_q),
		.prio_c   (prio_c_q),
		.ext_prio (ext_prio_s1),
		.best     (hp_best)
	);

	// ---- stage 2: output register ------------------------------------------
	logic [ips_pkg::PRIO_W-1:0] hp_s2;
	logic                       tk_valid_s2;
	logic [ips_pkg::CODE_W-1:0] tk_code_s2;
	logic [ips_pkg::SRC_W-1:0]  tk_src_s2;

	always_ff @(posedge clk) begin
		if (adv_out && s1_valid_q) begin
			hp_s2       <= hp_best.found ? hp_best.prio : '0;
			tk_valid_s2 <= tk_valid_s1;
			tk_code_s2  <= tk_code_s1;
			tk_src_s2   <= tk_src_s1;
		end
	end

	assign m_axis_tdata = {1'b0, tk_src_s2, tk_code_s2, tk_valid_s2, hp_s2};

endmodule

>>> rtl/ips_checker.sv
// ---------------------------------------------------------------------------
// Interrupt priority selector: port checker
// Watches result items and the output handshake.
// ---------------------------------------------------------------------------
`include "interrupt_priority_selector_defines.svh"

module ips_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	logic [4:0]  hp;
	logic        tk;
	logic [11:0] code;
	logic [4:0]  src;

	assign hp   = m_axis_tdata[4:0];
	assign tk   = m_axis_tdata[5];
	assign code = m_axis_tdata[17:6];
	assign src  = m_axis_tdata[22:18];

	`IPS_ASSERT_NOW(a_no_take_zero, clk, arst_n, m_axis_tvalid && !tk, code == 12'h000 && src == 5'd0, "idle result carries code or source")

	`IPS_ASSERT_NOW(a_prio_range, clk, arst_n, m_axis_tvalid, hp <= 5'd16, "highest priority above NMI level")

	`IPS_ASSERT_NOW(a_nmi_code, clk, arst_n, m_axis_tvalid && tk && src == 5'd0, code == 12'h1C0, "NMI taken with wrong event code")

	`IPS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind interrupt_priority_selector ips_port_checker u_ips_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
